// ===== hw/rtl/gsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsd_pkg: shared constants and tables for the 6-and-2 GCR sector decoder
// Code tables, field marks and helper functions for nibble translation.
// ----------------------------------------------------------------------------
package gsd_pkg;

	localparam int unsigned AUX_LEN = 86;
	localparam int unsigned AUX_AW  = $clog2(AUX_LEN);
	localparam int unsigned MAIN_LEN = 256;

	localparam logic [7:0] MARK_D5   = 8'hD5;
	localparam logic [7:0] MARK_AA   = 8'hAA;
	localparam logic [7:0] MARK_ADDR = 8'h96;
	localparam logic [7:0] MARK_DATA = 8'hAD;

	localparam logic [7:0] GCR_CODE [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	localparam logic [3:0] PHYS_TO_LOGICAL [16] = '{
		4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF
	};

	// Translate one nibble: {bad, value}; an untranslatable nibble gives bad
	// set and value 0xFF.
	function automatic logic [8:0] gsd_decode(input logic [7:0] nib);
		logic [5:0] idx;
		logic       hit;
		idx = '0;
		hit = 1'b0;
		for (int i = 0; i < 64; i++) begin
			if (GCR_CODE[i] == nib) begin
				idx = idx | 6'(i);
				hit = 1'b1;
			end
		end
		if (hit) begin
			return {1'b0, 2'b00, idx};
		end
		return {1'b1, 8'hFF};
	endfunction

endpackage

// ===== hw/rtl/gcr_6and2_sector_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_6and2_sector_decoder_core: streaming 6-and-2 GCR sector decoder
// Finds address and data fields in a raw nibble stream, decodes the header
// and emits one tagged byte per main data nibble plus an end-of-sector status.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | direction | word
//  ---------+---------------------------------------+-----------+---------------
//  nibble   | nibble_valid, nibble_ready, nibble    | in        | raw disk byte
//  result   | result_valid, result_ready, kind,     | out       | data byte or
//           | track, sector, index, value,          |           | sector status
//           | header_bad, nibble_bad, data_bad      |           |
//
// One nibble is taken per cycle while nibble_ready is high; the control state
// and the XOR chain update in the accept cycle.
// A result passes stage 1 and then the result register: the auxiliary store
// is a synchronous RAM whose read data lands in stage 1, and the result register follows.
// Reset clears the control state only; the auxiliary RAM needs no clearing,
// every data field writes all 86 entries before the first read.
// A stalled result stalls stage 1, and input is held off only when both the
// result register and stage 1 are full.
// ----------------------------------------------------------------------------
module gcr_6and2_sector_decoder_core
	import gsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       nibble_valid,
	output logic       nibble_ready,
	input  logic [7:0] nibble,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       kind,
	output logic [7:0] track,
	output logic [3:0] sector,
	output logic [7:0] index,
	output logic [7:0] value,
	output logic       header_bad,
	output logic       nibble_bad,
	output logic       data_bad
);

	// phase codes
	localparam logic [2:0] PH_HUNT_ADDR = 3'd0;
	localparam logic [2:0] PH_HEADER    = 3'd1;
	localparam logic [2:0] PH_HUNT_DATA = 3'd2;
	localparam logic [2:0] PH_AUX       = 3'd3;
	localparam logic [2:0] PH_MAIN      = 3'd4;
	localparam logic [2:0] PH_CSUM      = 3'd5;

	localparam logic [AUX_AW-1:0] AUX_LAST = AUX_AW'(AUX_LEN - 1);
	localparam logic [8:0]        AUX_CNT  = 9'(AUX_LEN);
	localparam logic [8:0]        MAIN_CNT = 9'(MAIN_LEN);
	localparam logic [7:0]        AUX_ONE  = 8'(AUX_LEN);
	localparam logic [7:0]        AUX_TWO  = 8'(2 * AUX_LEN);

	// decoder state
	logic [2:0] phase_q, phase_d;
	logic [1:0] pm_q, pm_d;
	logic [2:0] pair_q, pair_d;
	logic [7:0] hold_q, hold_d;
	logic [7:0] vol_q, vol_d;
	logic [7:0] trk_q, trk_d;
	logic [7:0] psec_q, psec_d;
	logic [7:0] chain_q, chain_d;
	logic [8:0] fc_q, fc_d;
	logic       bad_q, bad_d;
	logic       hbad_q, hbad_d;

	// auxiliary store
	logic [5:0]        aux_mem [AUX_LEN];
	logic              aux_we;
	logic [AUX_AW-1:0] aux_wa;
	logic [5:0]        aux_wd;
	logic              aux_re;
	logic [AUX_AW-1:0] aux_ra;

	// result word formed at accept
	logic       res_v;
	logic       res_kind;
	logic [7:0] res_index;
	logic [5:0] res_hi;
	logic [1:0] res_shift;
	logic       res_nbad;
	logic       res_dbad;

	// stage 1 and the result register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] track_s1;
	logic [3:0] sector_s1;
	logic [7:0] index_s1;
	logic [5:0] hi_s1;
	logic [1:0] shift_s1;
	logic       hbad_s1;
	logic       nbad_s1;
	logic       dbad_s1;
	logic [5:0] aux_rd_s1;
	logic [1:0] aux_pick;

	logic       valid_s2;
	logic       kind_s2;
	logic [7:0] track_s2;
	logic [3:0] sector_s2;
	logic [7:0] index_s2;
	logic [7:0] value_s2;
	logic       hbad_s2;
	logic       nbad_s2;
	logic       dbad_s2;

	logic       acc;
	logic       adv_s1;
	logic [8:0] dec;
	logic [7:0] chain_x;
	logic [7:0] pair_v;
	logic [7:0] k;
	logic [7:0] k_rem;

	assign adv_s1       = valid_s1 && (!valid_s2 || result_ready);
	assign nibble_ready = !valid_s1 || !valid_s2 || result_ready;
	assign acc          = nibble_valid && nibble_ready;

	assign dec     = gsd_decode(nibble);
	assign chain_x = dec[7:0] ^ chain_q;
	assign pair_v  = {hold_q[6:0], 1'b1} & nibble;
	assign k       = fc_q[7:0];

	always_comb begin
		phase_d   = phase_q;
		pm_d      = pm_q;
		pair_d    = pair_q;
		hold_d    = hold_q;
		vol_d     = vol_q;
		trk_d     = trk_q;
		psec_d    = psec_q;
		chain_d   = chain_q;
		fc_d      = fc_q;
		bad_d     = bad_q;
		hbad_d    = hbad_q;
		aux_we    = 1'b0;
		aux_wa    = AUX_LAST - fc_q[AUX_AW-1:0];
		aux_wd    = chain_x[5:0];
		aux_re    = 1'b0;
		res_v     = 1'b0;
		res_kind  = 1'b0;
		res_index = k;
		res_hi    = chain_x[5:0];
		res_nbad  = bad_q | dec[8];
		res_dbad  = 1'b0;
		// split the main index into aux slot and bit-pair select
		if (k >= AUX_TWO) begin
			k_rem     = k - AUX_TWO;
			res_shift = 2'd2;
		end else if (k >= AUX_ONE) begin
			k_rem     = k - AUX_ONE;
			res_shift = 2'd1;
		end else begin
			k_rem     = k;
			res_shift = 2'd0;
		end
		aux_ra = AUX_LAST - k_rem[AUX_AW-1:0];

		case (phase_q)
			PH_HUNT_ADDR, PH_HUNT_DATA: begin
				if (pm_q == 2'd0) begin
					pm_d = (nibble == MARK_D5) ? 2'd1 : 2'd0;
				end else if (pm_q == 2'd1) begin
					pm_d = (nibble == MARK_AA) ? 2'd2 :
						((nibble == MARK_D5) ? 2'd1 : 2'd0);
				end else begin
					pm_d = 2'd0;
					if (nibble == MARK_ADDR) begin
						phase_d = PH_HEADER;
						pair_d  = 3'd0;
					end else if (phase_q == PH_HUNT_DATA && nibble == MARK_DATA) begin
						phase_d = PH_AUX;
						fc_d    = '0;
						chain_d = '0;
						bad_d   = 1'b0;
					end else if (nibble == MARK_D5) begin
						pm_d = 2'd1;
					end
				end
			end
			PH_HEADER: begin
				if (!pair_q[0]) begin
					hold_d = nibble;
				end else begin
					case (pair_q[2:1])
						2'd0: vol_d = pair_v;
						2'd1: trk_d = pair_v;
						2'd2: psec_d = pair_v;
						default: begin
							hbad_d  = (pair_v != (vol_q ^ trk_q ^ psec_q)) ||
								(psec_q[7:4] != 4'd0);
							phase_d = PH_HUNT_DATA;
							pm_d    = 2'd0;
						end
					endcase
				end
				pair_d = pair_q + 3'd1;
			end
			PH_AUX: begin
				bad_d   = bad_q | dec[8];
				chain_d = chain_x;
				aux_we  = 1'b1;
				fc_d    = fc_q + 9'd1;
				if (fc_d >= AUX_CNT) begin
					phase_d = PH_MAIN;
					fc_d    = '0;
				end
			end
			PH_MAIN: begin
				bad_d   = bad_q | dec[8];
				chain_d = chain_x;
				aux_re  = 1'b1;
				res_v   = 1'b1;
				fc_d    = fc_q + 9'd1;
				if (fc_d >= MAIN_CNT) begin
					phase_d = PH_CSUM;
					fc_d    = '0;
				end
			end
			PH_CSUM: begin
				bad_d     = bad_q | dec[8];
				res_v     = 1'b1;
				res_kind  = 1'b1;
				res_index = '0;
				res_hi    = '0;
				res_shift = 2'd0;
				res_dbad  = dec[8] || (chain_x != 8'h00);
				phase_d   = PH_HUNT_ADDR;
				pm_d      = 2'd0;
			end
			default: begin
				phase_d = PH_HUNT_ADDR;
				pm_d    = 2'd0;
			end
		endcase
	end

	// advance the decoder state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_ADDR;
			pm_q    <= '0;
			pair_q  <= '0;
			hold_q  <= '0;
			vol_q   <= '0;
			trk_q   <= '0;
			psec_q  <= '0;
			chain_q <= '0;
			fc_q    <= '0;
			bad_q   <= 1'b0;
			hbad_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			pm_q    <= pm_d;
			pair_q  <= pair_d;
			hold_q  <= hold_d;
			vol_q   <= vol_d;
			trk_q   <= trk_d;
			psec_q  <= psec_d;
			chain_q <= chain_d;
			fc_q    <= fc_d;
			bad_q   <= bad_d;
			hbad_q  <= hbad_d;
		end
	end

	// aux RAM: writes come only in the aux phase and reads only in the main
	// phase of a later word, so the two never touch one entry in one cycle
	always_ff @(posedge clk) begin
		if (acc && aux_we) begin
			aux_mem[aux_wa] <= aux_wd;
		end
		if (acc && aux_re) begin
			aux_rd_s1 <= aux_mem[aux_ra];
		end
	end

	// stage 1: hold the result word while the RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc && res_v) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && res_v) begin
			kind_s1   <= res_kind;
			track_s1  <= trk_q;
			sector_s1 <= PHYS_TO_LOGICAL[psec_q[3:0]];
			index_s1  <= res_index;
			hi_s1     <= res_hi;
			shift_s1  <= res_shift;
			hbad_s1   <= hbad_q;
			nbad_s1   <= res_nbad;
			dbad_s1   <= res_dbad;
		end
	end

	// pick the bit pair of the aux entry for this third of the sector
	always_comb begin
		case (shift_s1)
			2'd0: aux_pick = aux_rd_s1[1:0];
			2'd1: aux_pick = aux_rd_s1[3:2];
			2'd2: aux_pick = aux_rd_s1[5:4];
			default: aux_pick = 2'b00;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2   <= kind_s1;
			track_s2  <= track_s1;
			sector_s2 <= sector_s1;
			index_s2  <= index_s1;
			value_s2  <= kind_s1 ? 8'h00 : {hi_s1, aux_pick[0], aux_pick[1]};
			hbad_s2   <= hbad_s1;
			nbad_s2   <= nbad_s1;
			dbad_s2   <= dbad_s1;
		end
	end

	assign result_valid = valid_s2;
	assign kind         = kind_s2;
	assign track        = track_s2;
	assign sector       = sector_s2;
	assign index        = index_s2;
	assign value        = value_s2;
	assign header_bad   = hbad_s2;
	assign nibble_bad   = nbad_s2;
	assign data_bad     = dbad_s2;

	// checks
	a_aux_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_AUX) |-> (fc_q < AUX_CNT))
		else $error("aux count past end of aux field");

	a_main_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MAIN) |-> (fc_q < MAIN_CNT))
		else $error("main count past end of data field");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind) |-> (index == 8'h00 && value == 8'h00))
		else $error("status word carries data");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(index_s1)))
		else $error("stage 1 word lost while stalled");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !kind) |-> !data_bad)
		else $error("data word flags checksum");

endmodule
